// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned PrioWidth    = 16;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned FillWidth    = 5;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic        [PrioWidth-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   extract;
    entry_t word;
  } cmd_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its entry against the incoming
// priority and keeps, takes the new word, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk_i,
  input  spq_pkg::cmd_t  cmd_i,
  input  logic           occupied_i,
  input  logic           prev_after_i,
  input  spq_pkg::entry_t prev_entry_i,
  input  spq_pkg::entry_t next_entry_i,
  output logic           after_o,
  output spq_pkg::entry_t entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  assign after_o = occupied_i && (entry_q.prio <= cmd_i.word.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && !after_o) begin
      entry_d = prev_after_i ? cmd_i.word : prev_entry_i;
    end else if (cmd_i.extract) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== design/stable_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Sorted priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One word is taken in every clock cycle: busy stays low, so start may be
// held high back to back. Each word gives exactly one result in the cycle after
// it is taken, shown for one cycle with done_o; the receiver cannot stall it.
// Every cell does its single compare-and-shift step at once. Entries of equal
// priority leave in arrival order. An insert into a full queue returns the
// full status and leaves the queue as it was; an extract from an empty queue
// returns the empty status.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation_i,
  input  logic signed [spq_pkg::ValueWidth-1:0] item_value_i,
  input  logic        [spq_pkg::PrioWidth-1:0]  item_priority_i,
  output logic                                  done_o,
  output logic [spq_pkg::StatusWidth-1:0]       status_o,
  output logic signed [spq_pkg::ValueWidth-1:0] out_value_o,
  output logic        [spq_pkg::PrioWidth-1:0]  out_priority_o,
  output logic [spq_pkg::FillWidth-1:0]         fill_count_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  full, empty;
  logic                  do_insert, do_extract;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [CntWidth+spq_pkg::FillWidth-1:0] count_wide;
  spq_pkg::cmd_t         cmd;
  spq_pkg::entry_t       cell_entry [DEPTH];
  logic [DEPTH-1:0]      cell_after;

  logic                  done_q;
  spq_pkg::status_e      status_q, status_d;
  spq_pkg::entry_t       out_q, out_d;
  logic [spq_pkg::FillWidth-1:0] fill_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntWidth'(DEPTH));
  assign empty  = (count_q == '0);

  assign do_insert  = accept && (operation_i == spq_pkg::OP_INSERT) && !full;
  assign do_extract = accept && (operation_i == spq_pkg::OP_EXTRACT) && !empty;

  assign cmd.insert     = do_insert;
  assign cmd.extract    = do_extract;
  assign cmd.word.value = item_value_i;
  assign cmd.word.prio  = item_priority_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            prev_after;
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_after = 1'b1;
      assign prev_entry = cmd.word;
    end else begin : g_body
      assign prev_after = cell_after[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (count_q > CntWidth'(i)),
      .prev_after_i (prev_after),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .after_o      (cell_after[i]),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_OK;
    out_d    = '0;
    if (accept) begin
      case (operation_i)
        spq_pkg::OP_INSERT: begin
          if (full) begin
            status_d = spq_pkg::ST_FULL;
          end else begin
            count_d = count_q + CntWidth'(1);
          end
        end
        spq_pkg::OP_EXTRACT: begin
          if (empty) begin
            status_d = spq_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - CntWidth'(1);
            out_d   = cell_entry[0];
          end
        end
        default: begin
          status_d = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  assign count_wide = {{spq_pkg::FillWidth{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    out_q    <= out_d;
    fill_q   <= count_wide[spq_pkg::FillWidth-1:0];
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_value_o    = out_q.value;
  assign out_priority_o = out_q.prio;
  assign fill_count_o   = fill_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(DEPTH))
    else $error("entry count above depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted word");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CntWidth'(1))
    else $error("insert did not grow the queue");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntWidth'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("head entries out of order");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == spq_pkg::OP_EXTRACT) && empty
      |=> status_o == spq_pkg::ST_EMPTY && fill_count_o == '0)
    else $error("extract on empty queue misreported");
`endif

endmodule

// ===== tb/sv/stable_priority_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit_tb
// Self-checking bench for the sorted, arrival-stable priority queue.
// A mirror of the sorted entry list predicts status, value, priority and fill
// for every accepted word and checks each done_o strobe against it in order.
// Directed words cover empty, full and tie cases; random phases then swing
// the fill level between empty and full with mostly tied priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit_tb;

  localparam int unsigned Depth      = spq_pkg::DepthDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [spq_pkg::StatusWidth-1:0]       st;
    logic signed [spq_pkg::ValueWidth-1:0] value;
    logic [spq_pkg::PrioWidth-1:0]         prio;
    logic [spq_pkg::FillWidth-1:0]         fill;
  } outcome_t;

  class queue_mirror;
    logic signed [spq_pkg::ValueWidth-1:0] held_value [Depth];
    logic [spq_pkg::PrioWidth-1:0]         held_prio  [Depth];
    int unsigned                           held_count;
    outcome_t                              due_results [$];
    int unsigned                           mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void note_word(spq_pkg::op_e op, logic signed [spq_pkg::ValueWidth-1:0] v,
                            logic [spq_pkg::PrioWidth-1:0] p);
      outcome_t    r;
      int unsigned pos;
      r    = '0;
      r.st = spq_pkg::ST_OK;
      if (op == spq_pkg::OP_INSERT) begin
        if (held_count >= Depth) begin
          r.st = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] <= p) pos++;
          for (int unsigned k = held_count; k > pos; k--) begin
            held_value[k] = held_value[k-1];
            held_prio[k]  = held_prio[k-1];
          end
          held_value[pos] = v;
          held_prio[pos]  = p;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.st = spq_pkg::ST_EMPTY;
        end else begin
          r.value = held_value[0];
          r.prio  = held_prio[0];
          for (int unsigned k = 1; k < held_count; k++) begin
            held_value[k-1] = held_value[k];
            held_prio[k-1]  = held_prio[k];
          end
          held_count--;
        end
      end
      r.fill = spq_pkg::FillWidth'(held_count);
      due_results.push_back(r);
    endfunction

    function void check_result(logic [spq_pkg::StatusWidth-1:0] st,
                               logic signed [spq_pkg::ValueWidth-1:0] v,
                               logic [spq_pkg::PrioWidth-1:0] p,
                               logic [spq_pkg::FillWidth-1:0] f);
      outcome_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: status=%0d value=%0d prio=%0d fill=%0d",
                   st, v, p, f);
        return;
      end
      want = due_results.pop_front();
      if (st !== want.st || v !== want.value || p !== want.prio || f !== want.fill) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display({"mismatch: expected status=%0d value=%0d prio=%0d fill=%0d,",
                    " got status=%0d value=%0d prio=%0d fill=%0d"},
                   want.st, want.value, want.prio, want.fill, st, v, p, f);
      end
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  start;
  logic                                  busy;
  logic                                  operation_i;
  logic signed [spq_pkg::ValueWidth-1:0] item_value_i;
  logic [spq_pkg::PrioWidth-1:0]         item_priority_i;
  logic                                  done_o;
  logic [spq_pkg::StatusWidth-1:0]       status_o;
  logic signed [spq_pkg::ValueWidth-1:0] out_value_o;
  logic [spq_pkg::PrioWidth-1:0]         out_priority_o;
  logic [spq_pkg::FillWidth-1:0]         fill_count_o;

  queue_mirror mirror = new();
  int unsigned cycle_count = 0;

  stable_priority_queue_unit #(.DEPTH(Depth)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .fill_count_o   (fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        mirror.check_result(status_o, out_value_o, out_priority_o, fill_count_o);
      if (start && !busy)
        mirror.note_word(spq_pkg::op_e'(operation_i), item_value_i, item_priority_i);
    end
  end

  task automatic send_word(spq_pkg::op_e op, logic signed [spq_pkg::ValueWidth-1:0] v,
                           logic [spq_pkg::PrioWidth-1:0] p);
    start           <= 1'b1;
    operation_i     <= op;
    item_value_i    <= v;
    item_priority_i <= p;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [spq_pkg::PrioWidth-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return spq_pkg::PrioWidth'($urandom_range(0, 7));
    if (r < 70)
      return ($urandom_range(0, 1) != 0) ? {spq_pkg::PrioWidth{1'b1}}
                                          : {spq_pkg::PrioWidth{1'b0}};
    return spq_pkg::PrioWidth'($urandom);
  endfunction

  function automatic logic signed [spq_pkg::ValueWidth-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return {1'b0, {(spq_pkg::ValueWidth-1){1'b1}}};
    if (r < 10) return {1'b1, {(spq_pkg::ValueWidth-1){1'b0}}};
    return spq_pkg::ValueWidth'($urandom);
  endfunction

  initial begin
    int unsigned  insert_pct;
    bit           burst;
    spq_pkg::op_e op;

    rst_ni          <= 1'b0;
    start           <= 1'b0;
    operation_i     <= spq_pkg::OP_INSERT;
    item_value_i    <= '0;
    item_priority_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, ties, extremes, full
    send_word(spq_pkg::OP_EXTRACT, 32'sd5, 16'd9);
    send_word(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    send_word(spq_pkg::OP_INSERT, 32'sh8000_0000, 16'h0000);
    send_word(spq_pkg::OP_INSERT, 32'sd0, 16'h0000);
    idle_for(2);
    send_word(spq_pkg::OP_INSERT, -32'sd1, 16'h8000);
    send_word(spq_pkg::OP_INSERT, 32'sd1, 16'h8000);
    send_word(spq_pkg::OP_INSERT, 32'sh5555_5555, 16'h5555);
    idle_for(1);
    send_word(spq_pkg::OP_INSERT, 32'shAAAA_AAAA, 16'hAAAA);
    for (int i = 0; i < 9; i++) begin
      send_word(spq_pkg::OP_INSERT, pick_value(), (i % 3 == 0) ? 16'hFFFF : 16'd3);
      if (i == 4) idle_for(3);
    end
    send_word(spq_pkg::OP_INSERT, 32'sd42, 16'h0000);
    for (int i = 0; i < 6; i++) send_word(spq_pkg::OP_EXTRACT, pick_value(), pick_prio());

    // random phases swing the fill level
    for (int ph = 0; ph < 30; ph++) begin
      case (ph % 4)
        0: insert_pct = 80;
        1: insert_pct = 50;
        2: insert_pct = 20;
        default: insert_pct = $urandom_range(30, 70);
      endcase
      burst = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 60; i++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_EXTRACT;
        send_word(op, pick_value(), pick_prio());
        if (!burst) idle_for(pick_gap());
      end
    end

    start <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mirror.due_results.size() != 0) mirror.mismatches++;

    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== stable_priority_queue_unit.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_unit.sv
tb/sv/stable_priority_queue_unit_tb.sv
